>>> src/utlsr_pkg.sv
package utlsr_pkg;

  // ring geometry
  localparam int LINE_SLOTS = 16;
  localparam int ROWS_SHOWN = 4;
  localparam int LINE_BYTES = 64;

  // derived widths
  localparam int SLOT_W = $clog2(LINE_SLOTS);
  localparam int BYTE_W = $clog2(LINE_BYTES);
  localparam int LEN_W  = BYTE_W;
  localparam int CNT_W  = $clog2(LINE_SLOTS + 1);
  localparam int TOT_W  = $clog2(LINE_SLOTS + 2);
  localparam int IDX_W  = $clog2(LINE_SLOTS + 4);
  localparam int WRAP_W = SLOT_W + 2;
  localparam int ADDR_W = SLOT_W + BYTE_W;
  localparam int MAX_LEN = LINE_BYTES - 2;

  // operation codes
  typedef enum logic [3:0] {
    OP_APPEND = 4'd0,
    OP_COMMIT = 4'd1,
    OP_TOGGLE = 4'd2,
    OP_UP     = 4'd3,
    OP_DOWN   = 4'd4,
    OP_GONE   = 4'd5,
    OP_START  = 4'd6,
    OP_END    = 4'd7,
    OP_CLEAR  = 4'd8,
    OP_READ   = 4'd9
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_WR,
    S_TXT,
    S_OUT
  } state_e;

  typedef logic [7:0] byte_t;

  // top of view that shows the newest rows
  function automatic logic [SLOT_W-1:0] newest_top(input logic [TOT_W-1:0] total);
    logic [TOT_W-1:0] diff;
    diff = total - TOT_W'(ROWS_SHOWN);
    if (total > TOT_W'(ROWS_SHOWN)) begin
      return SLOT_W'(diff);
    end
    return '0;
  endfunction

endpackage

>>> src/utf8_text_line_scrollback_ring.sv
// Scrollback ring of text lines with UTF-8 encoding.
// Input channel (in_valid_i / in_stall_o) carries one op with a code point,
// a view row and a byte position; the output channel (out_valid_o /
// out_stall_i) returns exactly one result per op: the read byte, row
// presence and length (zero for ops other than read) and the status after
// the op. One op is worked on at a time; the next transfer is taken as soon
// as the sequencer is back in idle, even while the last result waits.
// Path from input transfer to result valid:
//   view, scroll, session and clear ops: straight to the result stage
//   commit and end: one line-length memory read, then the result stage
//   read: length read, then a text memory read when the byte lies inside
//   the row; append: straight to the result if the code point is dropped,
//   after the length read if the line is full, else the length read, then
//   one UTF-8 byte per text memory write (1 to 3 bytes written)
// Reset clears the ring indices, counters, flags and the line-length valid
// bits at once; text memory is not cleared, bytes past a row's length are
// never read. While out_stall_i is high the result holds; the next op runs
// up to its result stage and waits there, so no further op is taken.
module utf8_text_line_scrollback_ring
  import utlsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic [20:0] code_point_i,
  input  logic [1:0]  view_row_i,
  input  logic [5:0]  byte_pos_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_byte_o,
  output logic        row_present_o,
  output logic [5:0]  row_length_o,
  output logic        view_visible_o,
  output logic        line_open_o,
  output logic [4:0]  line_count_o,
  output logic [3:0]  view_top_o
);

  // memories
  byte_t            txt_mem [LINE_BYTES * LINE_SLOTS];
  logic [LEN_W-1:0] len_mem [LINE_SLOTS];

  // control state
  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    held_q, held_d;
  logic [SLOT_W-1:0]   top_q, top_d;
  logic                live_q, live_d;
  logic                vis_q, vis_d;
  logic [LINE_SLOTS-1:0] len_vld_q, len_vld_d;
  logic                out_valid_q, out_valid_d;

  // item registers
  op_e               op_q, op_d;
  byte_t             enc_q [3];
  byte_t             enc_d [3];
  logic [1:0]        n_q, n_d;
  logic [1:0]        k_q, k_d;
  logic [LEN_W-1:0]  used_q, used_d;
  logic [5:0]        pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              present_q, present_d;
  logic [LEN_W-1:0]  rlen_q, rlen_d;
  byte_t             rbyte_q, rbyte_d;

  // memory read data
  logic [LEN_W-1:0] len_rd_q;
  logic             len_rv_q;
  byte_t            txt_rd_q;

  // memory ports
  logic              len_re, len_we, txt_re, txt_we;
  logic [SLOT_W-1:0] len_raddr;
  logic [LEN_W-1:0]  len_wdata;
  logic [ADDR_W-1:0] txt_raddr, txt_waddr;
  byte_t             txt_wdata;

  // output payload
  byte_t       obyte_q;
  logic        opres_q;
  logic [5:0]  olen_q;
  logic        ovis_q, oopen_q;
  logic [4:0]  ocnt_q;
  logic [3:0]  otop_q;

  logic in_xfer, out_free, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  // utf-8 encoding of the incoming code point
  logic       drop_in;
  logic [1:0] n_in;
  byte_t      enc_in [3];
  always_comb begin
    drop_in = (code_point_i < 21'h20) || (code_point_i == 21'h7F) ||
              (code_point_i >= 21'h10000);
    enc_in[1] = {2'b10, code_point_i[5:0]};
    enc_in[2] = {2'b10, code_point_i[5:0]};
    if (code_point_i < 21'h80) begin
      n_in      = 2'd1;
      enc_in[0] = code_point_i[7:0];
    end else if (code_point_i < 21'h800) begin
      n_in      = 2'd2;
      enc_in[0] = {3'b110, code_point_i[10:6]};
    end else begin
      n_in      = 2'd3;
      enc_in[0] = {4'b1110, code_point_i[15:12]};
      enc_in[1] = {2'b10, code_point_i[11:6]};
    end
  end

  // row lookup for reads
  logic [IDX_W-1:0]  idx_in;
  logic [WRAP_W-1:0] wrap_sum;
  logic [SLOT_W-1:0] slot_in;
  logic              present_in;
  logic [TOT_W-1:0]  total;
  always_comb begin
    idx_in   = IDX_W'(top_q) + IDX_W'(view_row_i);
    wrap_sum = WRAP_W'(head_q) + WRAP_W'(LINE_SLOTS) + WRAP_W'(idx_in) - WRAP_W'(held_q);
    if (wrap_sum >= WRAP_W'(LINE_SLOTS)) begin
      wrap_sum = wrap_sum - WRAP_W'(LINE_SLOTS);
    end
    slot_in    = head_q;
    present_in = 1'b0;
    if (idx_in < IDX_W'(held_q)) begin
      slot_in    = SLOT_W'(wrap_sum);
      present_in = 1'b1;
    end else if (live_q && (idx_in == IDX_W'(held_q))) begin
      present_in = 1'b1;
    end
    total = TOT_W'(held_q) + TOT_W'(live_q);
  end

  // line length as read back, zero for never-written slots
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] used_now;
  logic [LEN_W:0]   grown;
  logic             fits;
  assign len_eff  = len_rv_q ? len_rd_q : '0;
  assign used_now = live_q ? len_eff : '0;
  assign grown    = {1'b0, used_now} + (LEN_W + 1)'(n_q);
  assign fits     = grown <= (LEN_W + 1)'(MAX_LEN);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_e'(op_i))
            OP_APPEND: state_d = drop_in ? S_OUT : S_LEN;
            OP_COMMIT, OP_END, OP_READ: state_d = S_LEN;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_LEN: begin
        case (op_q)
          OP_APPEND: state_d = fits ? S_WR : S_OUT;
          OP_READ:   state_d = (LEN_W'(pos_q) < len_eff) && present_q ? S_TXT : S_OUT;
          default:   state_d = S_OUT;
        endcase
      end
      S_WR:    state_d = (k_q == n_q - 2'd1) ? S_OUT : S_WR;
      S_TXT:   state_d = S_OUT;
      S_OUT:   state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  logic [CNT_W-1:0] held_inc;
  assign held_inc = (held_q < CNT_W'(LINE_SLOTS)) ? held_q + CNT_W'(1) : held_q;

  always_comb begin
    head_d    = head_q;
    held_d    = held_q;
    top_d     = top_q;
    live_d    = live_q;
    vis_d     = vis_q;
    len_vld_d = len_vld_q;
    op_d      = op_q;
    enc_d     = enc_q;
    n_d       = n_q;
    k_d       = k_q;
    used_d    = used_q;
    pos_d     = pos_q;
    slot_d    = slot_q;
    present_d = present_q;
    rlen_d    = rlen_q;
    rbyte_d   = rbyte_q;
    len_re    = 1'b0;
    len_raddr = head_q;
    len_we    = 1'b0;
    len_wdata = LEN_W'(grown);
    txt_re    = 1'b0;
    txt_raddr = {slot_q, BYTE_W'(pos_q)};
    txt_we    = 1'b0;
    txt_waddr = {head_q, used_q + LEN_W'(k_q)};
    txt_wdata = enc_q[k_q];

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d      = op_e'(op_i);
          enc_d     = enc_in;
          n_d       = n_in;
          k_d       = '0;
          pos_d     = byte_pos_i;
          slot_d    = slot_in;
          present_d = 1'b0;
          rlen_d    = '0;
          rbyte_d   = '0;
          case (op_e'(op_i))
            OP_APPEND, OP_COMMIT, OP_END: begin
              len_re    = 1'b1;
              len_raddr = head_q;
            end
            OP_READ: begin
              len_re    = 1'b1;
              len_raddr = slot_in;
              present_d = present_in;
            end
            OP_TOGGLE: begin
              if (vis_q) begin
                vis_d = 1'b0;
              end else begin
                vis_d = 1'b1;
                top_d = newest_top(total);
              end
            end
            OP_UP: begin
              if (vis_q && (top_q != '0)) begin
                top_d = top_q - SLOT_W'(1);
              end
            end
            OP_DOWN: begin
              if (vis_q && (top_q < newest_top(total))) begin
                top_d = top_q + SLOT_W'(1);
              end
            end
            OP_GONE: vis_d = 1'b0;
            OP_START: begin
              vis_d  = 1'b0;
              live_d = 1'b0;
            end
            OP_CLEAR: begin
              head_d    = '0;
              held_d    = '0;
              top_d     = '0;
              live_d    = 1'b0;
              vis_d     = 1'b0;
              len_vld_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_LEN: begin
        case (op_q)
          OP_APPEND: begin
            used_d = used_now;
            live_d = 1'b1;
          end
          OP_COMMIT, OP_END: begin
            if (live_q) begin
              live_d = 1'b0;
              if (len_eff != '0) begin
                head_d = (head_q == SLOT_W'(LINE_SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
                held_d = held_inc;
                top_d  = newest_top(TOT_W'(held_inc));
              end
            end
            if (op_q == OP_END) begin
              vis_d = 1'b0;
            end
          end
          OP_READ: begin
            if (present_q) begin
              rlen_d = len_eff;
              if (LEN_W'(pos_q) < len_eff) begin
                txt_re = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_WR: begin
        txt_we = 1'b1;
        k_d    = k_q + 2'd1;
        if (k_q == n_q - 2'd1) begin
          len_we            = 1'b1;
          len_wdata         = used_q + LEN_W'(n_q);
          len_vld_d[head_q] = 1'b1;
        end
      end
      S_TXT: rbyte_d = txt_rd_q;
      default: ;
    endcase
  end

  // output register
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      held_q      <= '0;
      top_q       <= '0;
      live_q      <= 1'b0;
      vis_q       <= 1'b0;
      len_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      held_q      <= held_d;
      top_q       <= top_d;
      live_q      <= live_d;
      vis_q       <= vis_d;
      len_vld_q   <= len_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    enc_q     <= enc_d;
    n_q       <= n_d;
    k_q       <= k_d;
    used_q    <= used_d;
    pos_q     <= pos_d;
    slot_q    <= slot_d;
    present_q <= present_d;
    rlen_q    <= rlen_d;
    rbyte_q   <= rbyte_d;
    if (out_load) begin
      obyte_q <= rbyte_q;
      opres_q <= present_q;
      olen_q  <= 6'(rlen_q);
      ovis_q  <= vis_q;
      oopen_q <= live_q;
      ocnt_q  <= 5'(held_q);
      otop_q  <= 4'(top_q);
    end
  end

  // line length memory
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[head_q] <= len_wdata;
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_raddr];
      len_rv_q <= len_vld_q[len_raddr];
    end
  end

  // text memory
  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      txt_mem[txt_waddr] <= txt_wdata;
    end
    if (txt_re) begin
      txt_rd_q <= txt_mem[txt_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = obyte_q;
  assign row_present_o  = opres_q;
  assign row_length_o   = olen_q;
  assign view_visible_o = ovis_q;
  assign line_open_o    = oopen_q;
  assign line_count_o   = ocnt_q;
  assign view_top_o     = otop_q;

endmodule

>>> src/utlsr_checker.sv
module utlsr_checker
  import utlsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  read_byte_o,
  input  logic        row_present_o,
  input  logic [5:0]  row_length_o,
  input  logic [4:0]  line_count_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one op at a time: busy right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an op is in flight");

  // an absent row reports no text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_present_o |-> (read_byte_o == 8'd0) && (row_length_o == 6'd0))
    else $error("absent row returned text");

  // count and row length stay within the ring limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_count_o <= 5'(LINE_SLOTS)) && (row_length_o <= 6'(MAX_LEN)))
    else $error("count or row length out of range");

endmodule

bind utf8_text_line_scrollback_ring utlsr_checker u_utlsr_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import utlsr_pkg::*;

  // op codes the block leaves alone
  localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 290;

  typedef struct packed {
    logic [3:0]  op;
    logic [20:0] code_point;
    logic [1:0]  view_row;
    logic [5:0]  byte_pos;
  } line_op_t;

  typedef struct packed {
    byte_t             read_byte;
    logic              row_present;
    logic [LEN_W-1:0]  row_length;
    logic              view_visible;
    logic              line_open;
    logic [CNT_W-1:0]  line_count;
    logic [SLOT_W-1:0] view_top;
  } line_status_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [3:0]  op_i           = '0;
  logic [20:0] code_point_i   = '0;
  logic [1:0]  view_row_i     = '0;
  logic [5:0]  byte_pos_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  read_byte_o;
  logic        row_present_o;
  logic [5:0]  row_length_o;
  logic        view_visible_o;
  logic        line_open_o;
  logic [4:0]  line_count_o;
  logic [3:0]  view_top_o;

  utf8_text_line_scrollback_ring u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .code_point_i   (code_point_i),
    .view_row_i     (view_row_i),
    .byte_pos_i     (byte_pos_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_byte_o    (read_byte_o),
    .row_present_o  (row_present_o),
    .row_length_o   (row_length_o),
    .view_visible_o (view_visible_o),
    .line_open_o    (line_open_o),
    .line_count_o   (line_count_o),
    .view_top_o     (view_top_o)
  );

  line_op_t     pending_q[$];
  line_status_t expected_q[$];
  int           queued_total = 0;
  int           fail_count   = 0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  bit           hold_req      = 1'b0;
  int           hold_left     = 0;
  int           cycle_count   = 0;

  // scrollback state as the block should hold it
  byte_t             text_mem [LINE_SLOTS*LINE_BYTES];
  logic [LEN_W-1:0]  slot_len [LINE_SLOTS];
  logic [SLOT_W-1:0] head_slot;
  logic [CNT_W-1:0]  held_lines;
  logic [SLOT_W-1:0] first_row;
  logic              live_line;
  logic              log_shown;

  function automatic void clear_scrollback();
    foreach (text_mem[i]) text_mem[i] = '0;
    foreach (slot_len[i]) slot_len[i] = '0;
    head_slot  = '0;
    held_lines = '0;
    first_row  = '0;
    live_line  = 1'b0;
    log_shown  = 1'b0;
  endfunction

  // first row index that puts the newest lines in view
  function automatic int newest_first_row(int total);
    return (total > ROWS_SHOWN) ? total - ROWS_SHOWN : 0;
  endfunction

  function automatic void close_live_line();
    if (live_line) begin
      live_line = 1'b0;
      if (slot_len[head_slot] != 0) begin
        head_slot = SLOT_W'((int'(head_slot) + 1) % LINE_SLOTS);
        if (held_lines < LINE_SLOTS) held_lines = held_lines + CNT_W'(1);
        first_row = SLOT_W'(newest_first_row(int'(held_lines)));
      end
    end
  endfunction

  // apply one op to the scrollback state and work out its status
  function automatic line_status_t apply_line_op(line_op_t it);
    line_status_t res;
    byte_t        enc [3];
    logic [20:0]  cp;
    int           n;
    int           used;
    int           idx;
    int           slot;
    bit           hit;
    res = '0;
    cp  = it.code_point;
    case (it.op)
      OP_APPEND: begin
        n = 0;
        if (cp >= 21'h20 && cp != 21'h7F && cp < 21'h10000) begin
          if (cp < 21'h80) begin
            enc[0] = cp[7:0];
            n = 1;
          end else if (cp < 21'h800) begin
            enc[0] = 8'hC0 | 8'(cp[10:6]);
            enc[1] = 8'h80 | 8'(cp[5:0]);
            n = 2;
          end else begin
            enc[0] = 8'hE0 | 8'(cp[15:12]);
            enc[1] = 8'h80 | 8'(cp[11:6]);
            enc[2] = 8'h80 | 8'(cp[5:0]);
            n = 3;
          end
        end
        if (n != 0) begin
          if (!live_line) begin
            slot_len[head_slot] = '0;
            live_line = 1'b1;
          end
          used = int'(slot_len[head_slot]);
          // bytes that would overrun the line are dropped
          if (used + n <= MAX_LEN) begin
            for (int i = 0; i < n; i++)
              text_mem[ADDR_W'(int'(head_slot)*LINE_BYTES + used + i)] = enc[i];
            slot_len[head_slot] = LEN_W'(used + n);
          end
        end
      end
      OP_COMMIT: close_live_line();
      OP_TOGGLE: begin
        if (log_shown) begin
          log_shown = 1'b0;
        end else begin
          log_shown = 1'b1;
          first_row = SLOT_W'(newest_first_row(int'(held_lines) + int'(live_line)));
        end
      end
      OP_UP: begin
        if (log_shown && first_row > 0) first_row = first_row - SLOT_W'(1);
      end
      OP_DOWN: begin
        if (log_shown &&
            int'(first_row) < newest_first_row(int'(held_lines) + int'(live_line)))
          first_row = first_row + SLOT_W'(1);
      end
      OP_GONE: log_shown = 1'b0;
      OP_START: begin
        log_shown = 1'b0;
        live_line = 1'b0;
      end
      OP_END: begin
        close_live_line();
        log_shown = 1'b0;
      end
      OP_CLEAR: clear_scrollback();
      OP_READ: begin
        idx  = int'(first_row) + int'(it.view_row);
        slot = 0;
        hit  = 1'b0;
        if (idx < int'(held_lines)) begin
          slot = (int'(head_slot) + LINE_SLOTS - int'(held_lines) + idx) % LINE_SLOTS;
          hit  = 1'b1;
        end else if (live_line && idx == int'(held_lines)) begin
          // with a full ring the live slot is also the oldest row
          slot = int'(head_slot);
          hit  = 1'b1;
        end
        if (hit) begin
          res.row_present = 1'b1;
          res.row_length  = slot_len[SLOT_W'(slot)];
          if (it.byte_pos < slot_len[SLOT_W'(slot)])
            res.read_byte = text_mem[ADDR_W'(slot*LINE_BYTES + int'(it.byte_pos))];
        end
      end
      default: ;
    endcase
    res.view_visible = log_shown;
    res.line_open    = live_line;
    res.line_count   = held_lines;
    res.view_top     = first_row;
    return res;
  endfunction

  function automatic void queue_op(logic [3:0] op, logic [20:0] cp, logic [1:0] row,
                                   logic [5:0] pos);
    line_op_t it;
    it.op         = op;
    it.code_point = cp;
    it.view_row   = row;
    it.byte_pos   = pos;
    pending_q.push_back(it);
    queued_total++;
  endfunction

  // mostly printable text, with some code points that get dropped
  function automatic logic [20:0] random_code_point();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 21'($urandom_range(32, 126));
    if (pick < 70) return 21'($urandom_range(128, 2047));
    if (pick < 88) return 21'($urandom_range(2048, 65535));
    if (pick < 93) return 21'($urandom_range(0, 31));
    if (pick < 95) return 21'h7F;
    return 21'($urandom_range(65536, 2097151));
  endfunction

  task automatic queue_random_traffic(int n);
    int         target;
    int         kind;
    int         k;
    logic [3:0] op;
    target = queued_total + n;
    while (queued_total < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // one line of text closed by commit or end, sometimes too long
        k = ($urandom_range(0, 99) < 15) ? $urandom_range(15, 30) : $urandom_range(1, 8);
        repeat (k) queue_op(OP_APPEND, random_code_point(), 2'($urandom()), 6'($urandom()));
        op = ($urandom_range(0, 4) == 0) ? OP_END : OP_COMMIT;
        queue_op(op, 21'($urandom()), 2'($urandom()), 6'($urandom()));
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 6))
          queue_op(OP_READ, 21'($urandom()), 2'($urandom()),
                   6'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 20)
                                                 : $urandom_range(0, 63)));
      end else if (kind < 87) begin
        case ($urandom_range(0, 2))
          0:       op = OP_TOGGLE;
          1:       op = OP_UP;
          default: op = OP_DOWN;
        endcase
        queue_op(op, 21'($urandom()), 2'($urandom()), 6'($urandom()));
      end else if (kind < 91) begin
        op = $urandom_range(0, 1) ? OP_GONE : OP_START;
        queue_op(op, 21'($urandom()), 2'($urandom()), 6'($urandom()));
      end else if (kind < 92) begin
        queue_op(OP_CLEAR, 21'($urandom()), 2'($urandom()), 6'($urandom()));
      end else begin
        // any op with any fields
        queue_op(4'($urandom_range(0, 15)), 21'($urandom()), 2'($urandom()),
                 6'($urandom()));
      end
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // input driver: offer the next pending op once the current one is taken
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o)
      expected_q.push_back(apply_line_op(line_op_t'({op_i, code_point_i, view_row_i,
                                                      byte_pos_i})));
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        op_i         <= pending_q[0].op;
        code_point_i <= pending_q[0].code_point;
        view_row_i   <= pending_q[0].view_row;
        byte_pos_i   <= pending_q[0].byte_pos;
        void'(pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= HOLD_CYCLES;
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    line_status_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("read_byte", int'(want.read_byte), int'(read_byte_o));
        check_field("row_present", int'(want.row_present), int'(row_present_o));
        check_field("row_length", int'(want.row_length), int'(row_length_o));
        check_field("view_visible", int'(want.view_visible), int'(view_visible_o));
        check_field("line_open", int'(want.line_open), int'(line_open_o));
        check_field("line_count", int'(want.line_count), int'(line_count_o));
        check_field("view_top", int'(want.view_top), int'(view_top_o));
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_text_line_scrollback_ring test failed");
      $finish;
    end
  end

  initial begin
    clear_scrollback();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty read, code point extremes, every op
    queue_op(OP_READ,   21'h0,      2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h0,      2'd3, 6'd63);
    queue_op(OP_APPEND, 21'h1F,     2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h20,     2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h7E,     2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h7F,     2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h80,     2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h7FF,    2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h800,    2'd0, 6'd0);
    queue_op(OP_APPEND, 21'hD800,   2'd0, 6'd0);
    queue_op(OP_APPEND, 21'hFFFF,   2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h10000,  2'd0, 6'd0);
    queue_op(OP_APPEND, 21'h1FFFFF, 2'd0, 6'd0);
    queue_op(OP_READ,   21'h1FFFFF, 2'd0, 6'd0);
    queue_op(OP_READ,   21'h0,      2'd0, 6'd63);
    queue_op(OP_TOGGLE, 21'h0,      2'd0, 6'd0);
    queue_op(OP_COMMIT, 21'h0,      2'd0, 6'd0);
    queue_op(OP_COMMIT, 21'h0,      2'd0, 6'd0);
    queue_op(OP_READ,   21'h0,      2'd3, 6'd5);
    queue_op(OP_UP,     21'h0,      2'd0, 6'd0);
    queue_op(OP_DOWN,   21'h0,      2'd0, 6'd0);
    queue_op(OP_GONE,   21'h0,      2'd0, 6'd0);
    queue_op(OP_START,  21'h0,      2'd0, 6'd0);
    queue_op(OP_END,    21'h0,      2'd0, 6'd0);
    queue_op(OP_SPARE_FIRST, 21'h0, 2'd0, 6'd0);
    queue_op(OP_SPARE_LAST,  21'h0, 2'd0, 6'd0);
    queue_op(OP_CLEAR,  21'h0,      2'd0, 6'd0);
    while (pending_q.size() != 0) @(negedge clk_i);

    // no idling, with a long hold-off while the sender keeps offering
    queue_random_traffic(PHASE_ITEMS);
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);

    // sender gaps
    send_idle_pct = 54;
    queue_random_traffic(PHASE_ITEMS);
    while (pending_q.size() != 0) @(negedge clk_i);

    // receiver stalls
    send_idle_pct = 0;
    stall_pct     = 54;
    queue_random_traffic(PHASE_ITEMS);
    while (pending_q.size() != 0) @(negedge clk_i);

    // both sides
    send_idle_pct = 15;
    stall_pct     = 15;
    queue_random_traffic(PHASE_ITEMS);

    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("utf8_text_line_scrollback_ring test passed");
    end else begin
      $display("utf8_text_line_scrollback_ring test failed");
    end
    $finish;
  end

endmodule
